// ===== rtl/ostcr_pkg.sv =====
// Types, codes and constants shared by the one-shot timer modules.
`timescale 1ns / 1ps

package ostcr_pkg;

	localparam int TIME_WIDTH_DEF = 32;
	localparam int PERIOD_W       = 32;
	localparam int ELAPSED_W      = 32;
	localparam int CMD_W          = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK    = 3'd0,
		CMD_START_P = 3'd1,
		CMD_START   = 3'd2,
		CMD_STOP    = 3'd3,
		CMD_RESTART = 3'd4,
		CMD_QUERY   = 3'd5
	} cmd_e;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_PASS   = 5'b00010,
		ST_DECIDE = 5'b00100,
		ST_MOD    = 5'b01000,
		ST_DONE   = 5'b10000
	} state_e;

	typedef struct packed {
		logic [CMD_W-1:0]    command;
		logic [PERIOD_W-1:0] new_period;
	} in_word_t;

	typedef struct packed {
		logic                 expired;
		logic                 running;
		logic [ELAPSED_W-1:0] elapsed;
	} out_word_t;

	typedef struct packed {
		logic last;
		logic gt;
	} pass_stat_t;

endpackage

// ===== rtl/ostcr_bit_pass.sv =====
// Bit-serial increment of elapsed time and compare against the period, LSB first.
`timescale 1ns / 1ps

module ostcr_bit_pass #(
	parameter int TW = ostcr_pkg::TIME_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   cin,
	input  logic                   en,
	input  logic                   e_bit,
	input  logic                   p_bit,
	output logic                   sum_bit,
	output ostcr_pkg::pass_stat_t  stat
);
	import ostcr_pkg::*;

	localparam int CW = $clog2(TW);
	localparam logic [CW-1:0] LAST_CNT = CW'(TW - 1);

	logic [CW-1:0] cnt_q;
	logic          carry_q;
	logic          gt_q;
	logic          gt_next;

	assign sum_bit = e_bit ^ carry_q;
	assign gt_next = (e_bit & ~p_bit) | (~(e_bit ^ p_bit) & gt_q);
	assign stat.last = en && (cnt_q == LAST_CNT);
	assign stat.gt   = gt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			carry_q <= 1'b0;
			gt_q    <= 1'b0;
		end else if (start) begin
			cnt_q   <= '0;
			carry_q <= cin;
			gt_q    <= 1'b0;
		end else if (en) begin
			cnt_q   <= cnt_q + 1'b1;
			carry_q <= e_bit & carry_q;
			gt_q    <= gt_next;
		end
	end

endmodule

// ===== rtl/ostcr_rem.sv =====
// Restoring remainder unit: one dividend bit per cycle while en is high, MSB first.
`timescale 1ns / 1ps

module ostcr_rem #(
	parameter int TW = ostcr_pkg::TIME_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          en,
	input  logic          d_bit,
	input  logic [TW-1:0] divisor,
	output logic [TW-1:0] rem_next,
	output logic          last
);
	import ostcr_pkg::*;

	localparam int CW = $clog2(TW);
	localparam logic [CW-1:0] LAST_CNT = CW'(TW - 1);

	logic [CW-1:0] cnt_q;
	logic [TW-1:0] rem_q;
	logic [TW:0]   trial;
	logic [TW:0]   trial_sub;

	assign trial     = {rem_q, d_bit};
	assign trial_sub = trial - {1'b0, divisor};
	assign rem_next  = trial_sub[TW] ? trial[TW-1:0] : trial_sub[TW-1:0];
	assign last      = en && (cnt_q == LAST_CNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rem_q <= '0;
		end else if (start) begin
			cnt_q <= '0;
			rem_q <= '0;
		end else if (en) begin
			cnt_q <= cnt_q + 1'b1;
			rem_q <= rem_next;
		end
	end

endmodule

// ===== rtl/one_shot_timer_catchup_restart_core.sv =====
// One-shot tick timer with drift-free restart, bit-serial datapath.
//
//  channel | handshake            | word
//  --------+----------------------+------------------------------------
//  in      | in_valid / in_ready  | in_word  : command, new_period
//  out     | out_valid / out_ready| out_word : expired, running, elapsed
//
// Between one accept and the next, an item makes one serial pass through the elapsed
// and period shift registers, then a decide state and an output state. A restart of
// a timer that has expired or run past its period adds a pass through the restoring
// remainder unit.
// Reset clears time, flags and the output slot and sets the period to one.
// A waiting result stalls the output state; no new word is taken meanwhile.
`timescale 1ns / 1ps

module one_shot_timer_catchup_restart_core #(
	parameter int TIME_WIDTH = ostcr_pkg::TIME_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ostcr_pkg::in_word_t  in_word,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ostcr_pkg::out_word_t out_word
);
	import ostcr_pkg::*;

	localparam int TW = TIME_WIDTH;

	state_e           state_q;
	logic [CMD_W-1:0] cmd_q;
	logic [TW-1:0]    np_q;
	logic [TW-1:0]    elapsed_q;
	logic [TW-1:0]    period_q;
	logic             exp_q;
	logic             act_q;
	logic             out_valid_q;
	out_word_t        out_word_q;

	logic             accept;
	logic             pass_start;
	logic             sum_bit;
	pass_stat_t       pstat;
	logic             hit;
	logic             rem_start;
	logic             rem_en;
	logic [TW-1:0]    rem_next;
	logic             rem_last;
	logic             out_load;

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign pass_start = accept;
	assign hit        = act_q && pstat.gt;
	assign rem_start  = (state_q == ST_DECIDE);
	assign rem_en     = (state_q == ST_MOD);
	assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	ostcr_bit_pass #(.TW(TW)) u_pass (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (pass_start),
		.cin     (in_word.command == CMD_TICK),
		.en      (state_q == ST_PASS),
		.e_bit   (elapsed_q[0]),
		.p_bit   (period_q[0]),
		.sum_bit (sum_bit),
		.stat    (pstat)
	);

	ostcr_rem #(.TW(TW)) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.en       (rem_en),
		.d_bit    (elapsed_q[TW-1]),
		.divisor  (period_q),
		.rem_next (rem_next),
		.last     (rem_last)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= in_word.command;
			np_q  <= TW'(in_word.new_period);
		end
		if (out_load) begin
			out_word_q.expired <= exp_q;
			out_word_q.running <= act_q;
			out_word_q.elapsed <= ELAPSED_W'(elapsed_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			elapsed_q <= '0;
			period_q  <= TW'(1);
			exp_q     <= 1'b0;
			act_q     <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_PASS;
					end
				end
				ST_PASS: begin
					// advance both words one bit; period rotates back in place
					elapsed_q <= {sum_bit, elapsed_q[TW-1:1]};
					period_q  <= {period_q[0], period_q[TW-1:1]};
					if (pstat.last) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					state_q <= ST_DONE;
					unique case (cmd_q)
						CMD_TICK: begin
						end
						CMD_START_P: begin
							elapsed_q <= '0;
							exp_q     <= 1'b0;
							if (np_q != '0) begin
								period_q <= np_q;
								act_q    <= 1'b1;
							end else begin
								act_q <= 1'b0;
							end
						end
						CMD_START: begin
							elapsed_q <= '0;
							exp_q     <= 1'b0;
							act_q     <= 1'b1;
						end
						CMD_STOP: begin
							exp_q <= 1'b0;
							act_q <= 1'b0;
						end
						CMD_RESTART: begin
							if (hit || exp_q) begin
								state_q <= ST_MOD;
							end else begin
								elapsed_q <= '0;
								exp_q     <= 1'b0;
								act_q     <= 1'b1;
							end
						end
						CMD_QUERY: begin
							if (hit) begin
								exp_q <= 1'b1;
								act_q <= 1'b0;
							end
						end
						default: begin
						end
					endcase
				end
				ST_MOD: begin
					if (rem_last) begin
						elapsed_q <= rem_next;
						exp_q     <= 1'b0;
						act_q     <= 1'b1;
						state_q   <= ST_DONE;
					end else begin
						elapsed_q <= {elapsed_q[TW-2:0], 1'b0};
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_period_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		period_q != '0)
		else $error("period register holds zero");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(exp_q && act_q))
		else $error("timer both expired and running");

	a_mod_on_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MOD) |-> (cmd_q == CMD_RESTART))
		else $error("remainder pass outside restart");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result word loaded outside output cycle");
`endif

endmodule

// ===== test/timer_result_checker.sv =====
// Checker for the one-shot timer: predicts each result word from accepted input words.
`timescale 1ns / 1ps

module timer_result_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  ostcr_pkg::in_word_t  in_word,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  ostcr_pkg::out_word_t out_word,
	output int                   mismatches,
	output int                   outstanding
);
	import ostcr_pkg::*;

	logic [PERIOD_W-1:0] now_ticks;
	logic [PERIOD_W-1:0] start_ticks;
	logic [PERIOD_W-1:0] period_ticks;
	logic                expired_q;
	logic                active_q;
	out_word_t           timer_results[$];

	function automatic logic [PERIOD_W-1:0] ticks_since_start();
		return now_ticks - start_ticks;
	endfunction

	task automatic catch_expiry();
		if (active_q && ticks_since_start() > period_ticks) begin
			expired_q = 1'b1;
			active_q  = 1'b0;
		end
	endtask

	task automatic arm_timer();
		expired_q   = 1'b0;
		active_q    = 1'b1;
		start_ticks = now_ticks;
	endtask

	task automatic advance_timer(input in_word_t w, output out_word_t r);
		case (w.command)
			CMD_TICK: now_ticks = now_ticks + 1'b1;
			CMD_START_P: begin
				arm_timer();
				if (w.new_period != '0)
					period_ticks = w.new_period;
				else begin
					expired_q = 1'b0;
					active_q  = 1'b0;
				end
			end
			CMD_START: arm_timer();
			CMD_STOP: begin
				expired_q = 1'b0;
				active_q  = 1'b0;
			end
			CMD_RESTART: begin
				catch_expiry();
				if (expired_q) begin
					start_ticks = now_ticks - (ticks_since_start() % period_ticks);
					expired_q   = 1'b0;
					active_q    = 1'b1;
				end else
					arm_timer();
			end
			CMD_QUERY: catch_expiry();
			default: ;
		endcase
		r.expired = expired_q;
		r.running = active_q;
		r.elapsed = ticks_since_start();
	endtask

	task automatic report_mismatch(input string what);
		$display("[%0t] timer mismatch: %s", $time, what);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		out_word_t got;
		if (!arst_n) begin
			now_ticks    = '0;
			start_ticks  = '0;
			period_ticks = 1;
			expired_q    = 1'b0;
			active_q     = 1'b0;
			timer_results.delete();
			outstanding  = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (timer_results.size() == 0)
					report_mismatch($sformatf("unexpected word %h", out_word));
				else begin
					want = timer_results.pop_front();
					if (out_word.expired !== want.expired)
						report_mismatch($sformatf("expired %b, want %b",
							out_word.expired, want.expired));
					if (out_word.running !== want.running)
						report_mismatch($sformatf("running %b, want %b",
							out_word.running, want.running));
					if (out_word.elapsed !== want.elapsed)
						report_mismatch($sformatf("elapsed %h, want %h",
							out_word.elapsed, want.elapsed));
				end
			end
			if (in_valid && in_ready) begin
				advance_timer(in_word, got);
				timer_results.push_back(got);
			end
			outstanding = timer_results.size();
		end
	end

endmodule

// ===== test/one_shot_timer_catchup_restart_core_tb.sv =====
// Testbench top for the one-shot timer core: stimulus, pacing, watchdog and verdict.
`timescale 1ns / 1ps

module one_shot_timer_catchup_restart_core_tb;
	import ostcr_pkg::*;

	localparam int             CLK_PERIOD   = 12;
	localparam int             RESET_CYCLES = 6;
	localparam int             ITEM_COUNT   = 1200;
	localparam int             STALL_LIMIT  = 2000;
	localparam int             DRAIN_CYCLES = 2 * TIME_WIDTH_DEF + 16;
	localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_word_t  in_word;
	logic      out_valid;
	logic      out_ready;
	out_word_t out_word;
	int        mismatches;
	int        outstanding;
	int        burst_left;

	one_shot_timer_catchup_restart_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_word  (in_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word (out_word)
	);

	timer_result_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_word    (in_word),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_word   (out_word),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		int mode;
		int span;
		out_ready = 1'b0;
		forever begin
			mode = $urandom_range(0, 2);
			span = $urandom_range(1, 60);
			repeat (span) begin
				@(negedge clk);
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					default: out_ready <= 1'b0;
				endcase
			end
		end
	end

	initial begin
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
				idle = 0;
			else
				idle++;
		end
		$display("[one_shot_timer_catchup_restart_core] ERROR");
		$finish;
	end

	task automatic issue(input logic [CMD_W-1:0] cmd, input logic [PERIOD_W-1:0] period);
		in_word_t w;
		int       gap;
		w.command    = cmd;
		w.new_period = period;
		in_word  <= w;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 80) : $urandom_range(0, 4);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end else
			burst_left--;
	endtask

	initial begin
		logic [CMD_W-1:0]    cmd;
		logic [PERIOD_W-1:0] period;
		int                  pick;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		in_word    = '0;
		burst_left = 0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		issue(CMD_QUERY, '0);
		issue(CMD_SPARE_LO, 32'h5555_AAAA);
		issue(CMD_SPARE_HI, '1);
		issue(CMD_START_P, '0);
		issue(CMD_START_P, '1);
		issue(CMD_TICK, '0);
		issue(CMD_QUERY, '0);
		issue(CMD_START_P, 1);
		issue(CMD_TICK, '0);
		issue(CMD_QUERY, '0);
		issue(CMD_TICK, '0);
		issue(CMD_QUERY, '0);
		issue(CMD_RESTART, '0);
		issue(CMD_START_P, 3);
		repeat (5) issue(CMD_TICK, '0);
		issue(CMD_RESTART, '0);
		issue(CMD_TICK, '0);
		issue(CMD_TICK, '0);
		issue(CMD_QUERY, '0);
		issue(CMD_STOP, '0);
		issue(CMD_START, '0);
		issue(CMD_RESTART, '0);
		issue(CMD_STOP, '0);
		issue(CMD_RESTART, '0);
		issue(CMD_QUERY, '0);

		for (int i = 0; i < ITEM_COUNT; i++) begin
			pick   = $urandom_range(0, 99);
			period = $urandom;
			if (pick < 35)
				cmd = CMD_TICK;
			else if (pick < 55)
				cmd = CMD_QUERY;
			else if (pick < 70)
				cmd = CMD_RESTART;
			else if (pick < 80) begin
				cmd  = CMD_START_P;
				pick = $urandom_range(0, 9);
				if (pick < 7)
					period = $urandom_range(1, 12);
				else if (pick == 7)
					period = '0;
			end else if (pick < 86)
				cmd = CMD_START;
			else if (pick < 92)
				cmd = CMD_STOP;
			else
				cmd = $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
			issue(cmd, period);
		end
		in_valid <= 1'b0;

		while (outstanding != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("[one_shot_timer_catchup_restart_core] OK");
		else
			$display("[one_shot_timer_catchup_restart_core] ERROR");
		$finish;
	end

endmodule
